### design/iee_pkg.sv
// Shared types, constants and arithmetic helpers of the infix expression evaluator.
// Used by every module of the block; depends on nothing.
package iee_pkg;

  localparam int VS_DEPTH = 32;
  localparam int VS_AW    = $clog2(VS_DEPTH);
  localparam int VS_CW    = VS_AW + 1;
  localparam int OS_DEPTH = 32;
  localparam int OS_AW    = $clog2(OS_DEPTH);
  localparam int OS_CW    = OS_AW + 1;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int Q_CW     = Q_AW + 1;
  localparam int NUM_W    = 31;

  // Partial products per multiply (32x32 each)
  localparam logic [2:0] MUL_STEPS = 3'd4;

  localparam logic signed [63:0] Q_ONE   = 64'sh0000_0000_0001_0000;
  localparam logic signed [63:0] Q_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN   = 64'sh8000_0000_0000_0000;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_VALUE = 3'd1,
    ERR_OPER  = 3'd2,
    ERR_DIV0  = 3'd3,
    ERR_CHAR  = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POW  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    TK_NONE,
    TK_SPACE,
    TK_OPEN,
    TK_CLOSE,
    TK_OP,
    TK_BAD
  } tok_kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         error_code;
  } out_t;

  typedef struct packed {
    logic             last;
    logic             has_num;
    logic [NUM_W-1:0] num;
    tok_kind_t        kind;
    op_t              op;
  } token_t;

  typedef struct packed {
    op_t                op;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic               div_zero;
    logic signed [63:0] result;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    BE_IDLE,
    BE_PUSHNUM,
    BE_DISPATCH,
    BE_LOOP,
    BE_OPRD,
    BE_RDB,
    BE_RDA,
    BE_EXEC,
    BE_PUSHOP,
    BE_END,
    BE_FIN,
    BE_OUT
  } be_state_t;

  typedef enum logic [2:0] {
    AL_IDLE,
    AL_MUL,
    AL_DIV,
    AL_POW,
    AL_DONE
  } alu_state_t;

  function automatic logic [1:0] precedence(op_t op);
    case (op)
      OP_ADD, OP_SUB: precedence = 2'd1;
      OP_MUL, OP_DIV: precedence = 2'd2;
      OP_POW:         precedence = 2'd3;
      default:        precedence = 2'd0;
    endcase
  endfunction

  function automatic logic [63:0] mag_of(logic signed [63:0] x);
    mag_of = x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic signed [63:0] from_mag(logic neg, logic [63:0] mag, logic ovf);
    if (neg) begin
      from_mag = (ovf || mag[63]) ? Q_MIN : (64'sd0 - $signed(mag));
    end else begin
      from_mag = (ovf || mag[63]) ? Q_MAX : $signed(mag);
    end
  endfunction

  function automatic logic signed [63:0] trunc_q(logic signed [63:0] x);
    trunc_q = from_mag(x[63], mag_of(x) & ~64'h0000_0000_0000_FFFF, 1'b0);
  endfunction

endpackage

### design/iee_front.sv
// Front end: accepts characters, accumulates decimal numbers, classifies the rest.
// Emits one token per non-digit or final character. Depends on iee_pkg.
module iee_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             char_valid,
  output logic             char_ready,
  input  iee_pkg::in_t     char_item,
  input  logic             q_full,
  output logic             tok_valid,
  output iee_pkg::token_t  tok
);

  logic [iee_pkg::NUM_W-1:0] acc;
  logic                      in_num;
  logic                      accept;
  logic                      is_digit;
  logic [34:0]               prod;
  logic [iee_pkg::NUM_W-1:0] acc_next;
  iee_pkg::tok_kind_t        kind;
  iee_pkg::op_t              op;

  assign char_ready = !q_full;
  assign accept     = char_valid && char_ready;
  assign is_digit   = (char_item.char_code >= iee_pkg::CH_ZERO) &&
                      (char_item.char_code <= iee_pkg::CH_NINE);

  // Multiply by ten and add the digit, saturating at the 31-bit limit
  always_comb begin
    prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {31'b0, char_item.char_code[3:0]};
    if (prod > 35'h0_7FFF_FFFF) begin
      acc_next = {iee_pkg::NUM_W{1'b1}};
    end else begin
      acc_next = prod[iee_pkg::NUM_W-1:0];
    end
  end

  // Classify the character
  always_comb begin
    op   = iee_pkg::OP_OPEN;
    kind = iee_pkg::TK_BAD;
    case (char_item.char_code)
      iee_pkg::CH_SPACE: kind = iee_pkg::TK_SPACE;
      iee_pkg::CH_OPEN:  kind = iee_pkg::TK_OPEN;
      iee_pkg::CH_CLOSE: kind = iee_pkg::TK_CLOSE;
      iee_pkg::CH_PLUS: begin
        kind = iee_pkg::TK_OP;
        op   = iee_pkg::OP_ADD;
      end
      iee_pkg::CH_MINUS: begin
        kind = iee_pkg::TK_OP;
        op   = iee_pkg::OP_SUB;
      end
      iee_pkg::CH_STAR: begin
        kind = iee_pkg::TK_OP;
        op   = iee_pkg::OP_MUL;
      end
      iee_pkg::CH_SLASH: begin
        kind = iee_pkg::TK_OP;
        op   = iee_pkg::OP_DIV;
      end
      iee_pkg::CH_CARET: begin
        kind = iee_pkg::TK_OP;
        op   = iee_pkg::OP_POW;
      end
      default: kind = is_digit ? iee_pkg::TK_NONE : iee_pkg::TK_BAD;
    endcase
  end

  // Build the token for the back end
  assign tok_valid   = accept && (!is_digit || char_item.last_char);
  assign tok.last    = char_item.last_char;
  assign tok.has_num = in_num || is_digit;
  assign tok.num     = is_digit ? acc_next : acc;
  assign tok.kind    = kind;
  assign tok.op      = op;

  // Hold the number until a token carries it away
  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      in_num <= 1'b0;
    end else if (accept) begin
      if (tok_valid) begin
        acc    <= '0;
        in_num <= 1'b0;
      end else begin
        acc    <= acc_next;
        in_num <= 1'b1;
      end
    end
  end

endmodule

### design/iee_fifo.sv
// Short token queue between the front end and the back end.
// Depends on iee_pkg for the token type and depth.
module iee_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  iee_pkg::token_t  push_data,
  output logic             full,
  output logic             pop_valid,
  input  logic             pop,
  output iee_pkg::token_t  pop_data
);

  iee_pkg::token_t            mem [iee_pkg::Q_DEPTH];
  logic [iee_pkg::Q_AW-1:0]   wr_ptr;
  logic [iee_pkg::Q_AW-1:0]   rd_ptr;
  logic [iee_pkg::Q_CW-1:0]   count;
  logic                       do_push;
  logic                       do_pop;

  assign full      = (count == iee_pkg::Q_CW'(iee_pkg::Q_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {{(iee_pkg::Q_CW-1){1'b0}}, do_push}
                     - {{(iee_pkg::Q_CW-1){1'b0}}, do_pop};
    end
  end

endmodule

### design/iee_alu.sv
// Multi-cycle Q47.16 arithmetic unit: saturating add/sub, 4-step multiply,
// bit-serial divide and repeated-multiply power. Depends on iee_pkg.
module iee_alu (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  iee_pkg::alu_req_t  req,
  output iee_pkg::alu_rsp_t  rsp
);

  iee_pkg::alu_state_t state;
  iee_pkg::alu_state_t state_next;

  logic signed [63:0] a;
  logic signed [63:0] res;
  logic               dz;

  // Multiplier
  logic [63:0]  mx;
  logic [63:0]  my;
  logic         mneg;
  logic [2:0]   mcnt;
  logic         mrun;
  logic         pvalid;
  logic [63:0]  pp;
  logic [1:0]   psh;
  logic [127:0] acc;
  logic         mul_go;
  logic         mul_fin;
  logic signed [63:0] mx_in;
  logic signed [63:0] my_in;
  logic signed [63:0] mul_res;

  // Divider
  logic [127:0] dvd;
  logic [63:0]  rem;
  logic [63:0]  dd;
  logic [6:0]   dcnt;
  logic [63:0]  dq;
  logic         dovf;
  logic         dneg;
  logic [64:0]  rem2;
  logic         ge;
  logic [63:0]  dq_next;
  logic         dovf_next;

  // Power
  logic signed [63:0] pr;
  logic signed [63:0] pprev;
  logic [47:0]        pn;
  logic [47:0]        pi;
  logic signed [63:0] pnext;
  logic               pow_stop;
  logic signed [63:0] pow_res;
  logic [47:0]        pleft;

  logic signed [64:0] sum;
  logic signed [64:0] dif;
  logic [63:0]        bsum;

  assign mul_fin = mrun && (mcnt == iee_pkg::MUL_STEPS) && !pvalid;
  assign mul_res = iee_pkg::from_mag(mneg, acc[79:16], |acc[127:80]);
  assign pnext   = iee_pkg::trunc_q(mul_res);

  // Power loop exit tests
  always_comb begin
    pleft    = pn - 48'd1 - pi;
    pow_stop = 1'b0;
    pow_res  = pnext;
    if (pnext == pr) begin
      pow_stop = 1'b1;
      pow_res  = pr;
    end else if (pi != '0 && pnext == pprev) begin
      pow_stop = 1'b1;
      pow_res  = pleft[0] ? pr : pnext;
    end else if (pi + 48'd1 == pn) begin
      pow_stop = 1'b1;
    end
  end

  // Divider step
  always_comb begin
    rem2      = {rem, dvd[127]};
    ge        = (rem2 >= {1'b0, dd});
    dq_next   = {dq[62:0], ge & dcnt[6]};
    dovf_next = dovf | (ge & ~dcnt[6]);
  end

  // Add and subtract with saturation
  always_comb begin
    sum  = {req.a[63], req.a} + {req.b[63], req.b};
    dif  = {req.a[63], req.a} - {req.b[63], req.b};
    bsum = req.b + 64'h0000_0000_0000_FFFF;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      iee_pkg::AL_IDLE: begin
        if (start) begin
          case (req.op)
            iee_pkg::OP_MUL: state_next = iee_pkg::AL_MUL;
            iee_pkg::OP_DIV: state_next = (req.b == '0) ? iee_pkg::AL_DONE : iee_pkg::AL_DIV;
            iee_pkg::OP_POW: state_next = (req.b <= 0) ? iee_pkg::AL_DONE : iee_pkg::AL_POW;
            default:         state_next = iee_pkg::AL_DONE;
          endcase
        end
      end
      iee_pkg::AL_MUL: if (mul_fin) state_next = iee_pkg::AL_DONE;
      iee_pkg::AL_DIV: if (dcnt == 7'd127) state_next = iee_pkg::AL_DONE;
      iee_pkg::AL_POW: if (mul_fin && pow_stop) state_next = iee_pkg::AL_DONE;
      iee_pkg::AL_DONE: state_next = iee_pkg::AL_IDLE;
      default: state_next = iee_pkg::AL_IDLE;
    endcase
  end

  // Outputs and multiplier launch
  always_comb begin
    rsp.done     = (state == iee_pkg::AL_DONE);
    rsp.div_zero = dz;
    rsp.result   = res;
    mul_go       = 1'b0;
    mx_in        = req.a;
    my_in        = req.b;
    case (state)
      iee_pkg::AL_IDLE: begin
        if (start && req.op == iee_pkg::OP_MUL) begin
          mul_go = 1'b1;
        end else if (start && req.op == iee_pkg::OP_POW && req.b > 0) begin
          mul_go = 1'b1;
          mx_in  = iee_pkg::Q_ONE;
          my_in  = req.a;
        end
      end
      iee_pkg::AL_POW: begin
        mx_in = pnext;
        my_in = a;
        if (mul_fin && !pow_stop) begin
          mul_go = 1'b1;
        end
      end
      default: mul_go = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= iee_pkg::AL_IDLE;
      mrun   <= 1'b0;
      pvalid <= 1'b0;
      mcnt   <= '0;
    end else begin
      state <= state_next;
      if (mul_go) begin
        mrun   <= 1'b1;
        pvalid <= 1'b0;
        mcnt   <= '0;
      end else if (mrun) begin
        pvalid <= (mcnt != iee_pkg::MUL_STEPS);
        if (mcnt != iee_pkg::MUL_STEPS) begin
          mcnt <= mcnt + 3'd1;
        end
        if (mul_fin) begin
          mrun <= 1'b0;
        end
      end
    end
  end

  // Multiplier datapath: one 32x32 partial product per cycle, accumulate the next
  always_ff @(posedge clk) begin
    if (mul_go) begin
      mx   <= iee_pkg::mag_of(mx_in);
      my   <= iee_pkg::mag_of(my_in);
      mneg <= mx_in[63] ^ my_in[63];
      acc  <= '0;
    end else if (mrun) begin
      if (mcnt != iee_pkg::MUL_STEPS) begin
        pp  <= {32'b0, (mcnt[1] ? mx[63:32] : mx[31:0])} *
               {32'b0, (mcnt[0] ? my[63:32] : my[31:0])};
        psh <= {1'b0, mcnt[1]} + {1'b0, mcnt[0]};
      end
      if (pvalid) begin
        acc <= acc + ({64'b0, pp} << {psh, 5'b0});
      end
    end
  end

  // Operation datapath
  always_ff @(posedge clk) begin
    case (state)
      iee_pkg::AL_IDLE: begin
        if (start) begin
          a     <= req.a;
          dz    <= (req.op == iee_pkg::OP_DIV) && (req.b == '0);
          dd    <= iee_pkg::mag_of(req.b);
          dvd   <= {48'b0, iee_pkg::mag_of(req.a), 16'b0};
          rem   <= '0;
          dcnt  <= '0;
          dq    <= '0;
          dovf  <= 1'b0;
          dneg  <= req.a[63] ^ req.b[63];
          pr    <= iee_pkg::Q_ONE;
          pprev <= iee_pkg::Q_ONE;
          pi    <= '0;
          pn    <= bsum[63:16];
          case (req.op)
            iee_pkg::OP_ADD:
              res <= (sum[64] != sum[63]) ? (sum[64] ? iee_pkg::Q_MIN : iee_pkg::Q_MAX)
                                          : sum[63:0];
            iee_pkg::OP_SUB:
              res <= (dif[64] != dif[63]) ? (dif[64] ? iee_pkg::Q_MIN : iee_pkg::Q_MAX)
                                          : dif[63:0];
            iee_pkg::OP_POW: res <= iee_pkg::Q_ONE;
            default:         res <= req.a;
          endcase
        end
      end
      iee_pkg::AL_MUL: begin
        if (mul_fin) begin
          res <= mul_res;
        end
      end
      iee_pkg::AL_DIV: begin
        rem  <= ge ? (rem2[63:0] - dd) : rem2[63:0];
        dvd  <= {dvd[126:0], 1'b0};
        dq   <= dq_next;
        dovf <= dovf_next;
        dcnt <= dcnt + 7'd1;
        if (dcnt == 7'd127) begin
          res <= iee_pkg::from_mag(dneg, dq_next, dovf_next);
        end
      end
      iee_pkg::AL_POW: begin
        if (mul_fin) begin
          pprev <= pr;
          pr    <= pnext;
          pi    <= pi + 48'd1;
          res   <= pow_res;
        end
      end
      default: res <= res;
    endcase
  end

endmodule

### design/iee_back.sv
// Back end: runs tokens against the value and operator stacks and drives the
// result register. Depends on iee_pkg and iee_alu.
module iee_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  iee_pkg::token_t  q_data,
  output logic             q_pop,
  output logic             result_valid,
  input  logic             result_ready,
  output iee_pkg::out_t    result_item
);

  iee_pkg::be_state_t state;
  iee_pkg::be_state_t state_next;

  iee_pkg::token_t           tok;
  logic [iee_pkg::VS_CW-1:0] vd;
  logic [iee_pkg::OS_CW-1:0] od;
  iee_pkg::err_t             err;
  logic                      draining;
  iee_pkg::op_t              top_op;
  logic signed [63:0]        b_reg;

  // Stacks
  logic signed [63:0]        vs_mem [iee_pkg::VS_DEPTH];
  logic [2:0]                os_mem [iee_pkg::OS_DEPTH];
  logic signed [63:0]        vs_rdata;
  logic [2:0]                os_rdata;
  logic                      vs_we;
  logic [iee_pkg::VS_AW-1:0] vs_waddr;
  logic signed [63:0]        vs_wdata;
  logic [iee_pkg::VS_CW-1:0] vs_rsel;
  logic                      os_we;
  logic [iee_pkg::OS_AW-1:0] os_waddr;
  logic [2:0]                os_wdata;
  logic [iee_pkg::OS_CW-1:0] os_rsel;

  logic                      alu_start;
  iee_pkg::alu_req_t         alu_req;
  iee_pkg::alu_rsp_t         alu_rsp;

  iee_pkg::op_t              os_top;
  logic                      apply;
  logic                      out_load;
  logic                      vs_full;
  logic                      os_full;
  logic                      ok;
  logic [31:0]               final_value;

  iee_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign os_top   = iee_pkg::op_t'(os_rdata);
  assign vs_full  = (vd >= iee_pkg::VS_CW'(iee_pkg::VS_DEPTH));
  assign os_full  = (od >= iee_pkg::OS_CW'(iee_pkg::OS_DEPTH));
  assign ok       = (err == iee_pkg::ERR_NONE);
  assign out_load = (state == iee_pkg::BE_OUT) && (!result_valid || result_ready);
  assign os_rsel  = od - 1'b1;

  // Decide whether the stacked operator is applied now
  always_comb begin
    if (draining) begin
      apply = 1'b1;
    end else if (tok.kind == iee_pkg::TK_CLOSE) begin
      apply = (os_top != iee_pkg::OP_OPEN);
    end else begin
      apply = (iee_pkg::precedence(os_top) >= iee_pkg::precedence(tok.op));
    end
  end

  // Truncate the top value to a saturated 32-bit integer
  always_comb begin
    logic [63:0] m;
    logic [47:0] mi;
    m  = iee_pkg::mag_of(vs_rdata);
    mi = m[63:16];
    if (vs_rdata[63]) begin
      final_value = (mi > 48'h0000_8000_0000) ? 32'h8000_0000 : (32'd0 - mi[31:0]);
    end else begin
      final_value = (mi > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mi[31:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      iee_pkg::BE_IDLE:    if (q_valid) state_next = iee_pkg::BE_PUSHNUM;
      iee_pkg::BE_PUSHNUM: state_next = iee_pkg::BE_DISPATCH;
      iee_pkg::BE_DISPATCH: begin
        if (ok && (tok.kind == iee_pkg::TK_CLOSE || tok.kind == iee_pkg::TK_OP)) begin
          state_next = iee_pkg::BE_LOOP;
        end else begin
          state_next = iee_pkg::BE_END;
        end
      end
      iee_pkg::BE_LOOP: begin
        if (!ok || od == '0) begin
          if (draining) begin
            state_next = iee_pkg::BE_FIN;
          end else if (tok.kind == iee_pkg::TK_OP) begin
            state_next = iee_pkg::BE_PUSHOP;
          end else begin
            state_next = iee_pkg::BE_END;
          end
        end else begin
          state_next = iee_pkg::BE_OPRD;
        end
      end
      iee_pkg::BE_OPRD: begin
        if (apply) begin
          state_next = (vd < iee_pkg::VS_CW'(2)) ? iee_pkg::BE_LOOP : iee_pkg::BE_RDB;
        end else if (tok.kind == iee_pkg::TK_OP) begin
          state_next = iee_pkg::BE_PUSHOP;
        end else begin
          state_next = iee_pkg::BE_END;
        end
      end
      iee_pkg::BE_RDB:    state_next = iee_pkg::BE_RDA;
      iee_pkg::BE_RDA:    state_next = iee_pkg::BE_EXEC;
      iee_pkg::BE_EXEC:   if (alu_rsp.done) state_next = iee_pkg::BE_LOOP;
      iee_pkg::BE_PUSHOP: state_next = iee_pkg::BE_END;
      iee_pkg::BE_END:    state_next = tok.last ? iee_pkg::BE_LOOP : iee_pkg::BE_IDLE;
      iee_pkg::BE_FIN:    state_next = iee_pkg::BE_OUT;
      iee_pkg::BE_OUT:    if (out_load) state_next = iee_pkg::BE_IDLE;
      default:            state_next = iee_pkg::BE_IDLE;
    endcase
  end

  // Stack ports, queue pop and unit launch
  always_comb begin
    q_pop     = (state == iee_pkg::BE_IDLE) && q_valid;
    vs_we     = 1'b0;
    vs_waddr  = vd[iee_pkg::VS_AW-1:0];
    vs_wdata  = {17'b0, tok.num, 16'b0};
    vs_rsel   = vd - 1'b1;
    os_we     = 1'b0;
    os_waddr  = od[iee_pkg::OS_AW-1:0];
    os_wdata  = iee_pkg::OP_OPEN;
    alu_start = 1'b0;
    alu_req.op = top_op;
    alu_req.a  = vs_rdata;
    alu_req.b  = b_reg;
    case (state)
      iee_pkg::BE_PUSHNUM: vs_we = ok && tok.has_num && !vs_full;
      iee_pkg::BE_DISPATCH: os_we = ok && (tok.kind == iee_pkg::TK_OPEN) && !os_full;
      iee_pkg::BE_RDB:      vs_rsel = vd - 2'd2;
      iee_pkg::BE_RDA:      alu_start = 1'b1;
      iee_pkg::BE_EXEC: begin
        vs_wdata = alu_rsp.result;
        vs_we    = alu_rsp.done && !alu_rsp.div_zero && !vs_full;
      end
      iee_pkg::BE_PUSHOP: begin
        os_wdata = tok.op;
        os_we    = ok && !os_full;
      end
      default: vs_we = 1'b0;
    endcase
  end

  // Stack memories with registered reads
  always_ff @(posedge clk) begin
    if (vs_we) begin
      vs_mem[vs_waddr] <= vs_wdata;
    end
    vs_rdata <= vs_mem[vs_rsel[iee_pkg::VS_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (os_we) begin
      os_mem[os_waddr] <= os_wdata;
    end
    os_rdata <= os_mem[os_rsel[iee_pkg::OS_AW-1:0]];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == iee_pkg::BE_IDLE && q_valid) begin
      tok <= q_data;
    end
    if (state == iee_pkg::BE_OPRD) begin
      top_op <= os_top;
    end
    if (state == iee_pkg::BE_RDB) begin
      b_reg <= vs_rdata;
    end
    if (out_load) begin
      result_item.error_code <= err;
      result_item.value      <= ok ? $signed(final_value) : 32'sd0;
    end
  end

  // Control registers: depths, error latch, drain flag, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= iee_pkg::BE_IDLE;
      vd           <= '0;
      od           <= '0;
      err          <= iee_pkg::ERR_NONE;
      draining     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        iee_pkg::BE_PUSHNUM: begin
          if (ok && tok.has_num) begin
            if (vs_full) begin
              err <= iee_pkg::ERR_VALUE;
            end else begin
              vd <= vd + 1'b1;
            end
          end
        end
        iee_pkg::BE_DISPATCH: begin
          if (ok && tok.kind == iee_pkg::TK_OPEN) begin
            if (os_full) begin
              err <= iee_pkg::ERR_OPER;
            end else begin
              od <= od + 1'b1;
            end
          end else if (ok && tok.kind == iee_pkg::TK_BAD) begin
            err <= iee_pkg::ERR_CHAR;
          end
        end
        iee_pkg::BE_OPRD: begin
          if (apply) begin
            od <= od - 1'b1;
            if (vd < iee_pkg::VS_CW'(2)) begin
              err <= iee_pkg::ERR_VALUE;
            end
          end else if (tok.kind == iee_pkg::TK_CLOSE) begin
            od <= od - 1'b1;
          end
        end
        iee_pkg::BE_RDA: vd <= vd - 2'd2;
        iee_pkg::BE_EXEC: begin
          if (alu_rsp.done) begin
            if (alu_rsp.div_zero) begin
              err <= iee_pkg::ERR_DIV0;
            end else if (vs_full) begin
              err <= iee_pkg::ERR_VALUE;
            end else begin
              vd <= vd + 1'b1;
            end
          end
        end
        iee_pkg::BE_PUSHOP: begin
          if (ok) begin
            if (os_full) begin
              err <= iee_pkg::ERR_OPER;
            end else begin
              od <= od + 1'b1;
            end
          end
        end
        iee_pkg::BE_END: begin
          if (tok.last) begin
            draining <= 1'b1;
          end
        end
        iee_pkg::BE_FIN: begin
          if (ok && vd == '0) begin
            err <= iee_pkg::ERR_VALUE;
          end
        end
        iee_pkg::BE_OUT: begin
          if (out_load) begin
            vd       <= '0;
            od       <= '0;
            err      <= iee_pkg::ERR_NONE;
            draining <= 1'b0;
          end
        end
        default: draining <= draining;
      endcase
    end
  end

  // Depths never pass the stack sizes
  a_vd_bound: assert property (@(posedge clk) disable iff (rst)
    vd <= iee_pkg::VS_CW'(iee_pkg::VS_DEPTH))
    else $error("value depth beyond stack size");

  a_od_bound: assert property (@(posedge clk) disable iff (rst)
    od <= iee_pkg::OS_CW'(iee_pkg::OS_DEPTH))
    else $error("operator depth beyond stack size");

  // A failed expression reports value zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.error_code != iee_pkg::ERR_NONE |-> result_item.value == 0)
    else $error("error result with nonzero value");

  // The unit is launched only from the operand read state
  a_alu_launch: assert property (@(posedge clk) disable iff (rst)
    alu_start |=> state == iee_pkg::BE_EXEC)
    else $error("arithmetic unit launched out of sequence");

endmodule

### design/infix_expression_evaluator_unit.sv
// Infix expression evaluator: one character per transaction, one result per expression.
// Flow: a character reaches the token queue in the cycle after acceptance; the back end takes
// each token through IDLE, PUSHNUM, DISPATCH and END, an operator also through LOOP, OPRD and
// PUSHOP, and each applied operator through OPRD, RDB, RDA and EXEC until the unit is done.
// After the last token, FIN then OUT offers the result. Throughput: one character per cycle
// until the 4-entry token queue fills. Reset: synchronous rst empties queue, stacks and errors.
module infix_expression_evaluator_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           char_valid,
  output logic           char_ready,
  input  iee_pkg::in_t   char_item,
  output logic           result_valid,
  input  logic           result_ready,
  output iee_pkg::out_t  result_item
);

  logic            q_full;
  logic            tok_valid;
  iee_pkg::token_t tok;
  logic            q_valid;
  logic            q_pop;
  iee_pkg::token_t q_data;

  iee_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .q_full     (q_full),
    .tok_valid  (tok_valid),
    .tok        (tok)
  );

  iee_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (tok_valid),
    .push_data (tok),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  iee_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule
